// ----- design/lca_pkg.sv -----
`timescale 1ns / 1ps

package lca_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int LEVELS     = 10;
  localparam int NODE_W     = 10;
  localparam int DEPTH_W    = 11;
  localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_DEPTH  = NODE_COUNT * LEVELS;
  localparam int ANC_AW     = (ANC_DEPTH > 1) ? $clog2(ANC_DEPTH) : 1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [ANC_AW-1:0]  anc_addr_t;

  localparam logic  CMD_ADD   = 1'b0;
  localparam logic  CMD_QUERY = 1'b1;
  localparam node_t ROOT_NODE = node_t'(1);
  localparam node_t NULL_NODE = node_t'(0);
  localparam depth_t DEPTH_MAX = '1;

  typedef struct packed {
    node_t  anc_rd_node_a;
    lvl_t   anc_rd_lvl_a;
    node_t  anc_rd_node_b;
    lvl_t   anc_rd_lvl_b;
    logic   anc_we;
    node_t  anc_wr_node;
    lvl_t   anc_wr_lvl;
    node_t  anc_wr_data;
    node_t  dep_rd_node_a;
    node_t  dep_rd_node_b;
    logic   dep_we;
    node_t  dep_wr_node;
    depth_t dep_wr_data;
  } tbl_req_t;

  typedef struct packed {
    node_t  anc_q_a;
    node_t  anc_q_b;
    depth_t dep_q_a;
    depth_t dep_q_b;
    logic   clearing;
  } tbl_rsp_t;

  function automatic node_t map_node(input node_t v);
    return ({1'b0, v} < (NODE_W+1)'(NODE_COUNT)) ? v : NULL_NODE;
  endfunction

  function automatic anc_addr_t anc_addr(input node_t n, input lvl_t l);
    return anc_addr_t'(anc_addr_t'(n) * anc_addr_t'(LEVELS) + anc_addr_t'(l));
  endfunction

endpackage

// ----- design/lca_tables.sv -----
`timescale 1ns / 1ps

module lca_tables (
  input  logic              clk,
  input  logic              rst_n,
  input  lca_pkg::tbl_req_t req,
  output lca_pkg::tbl_rsp_t rsp
);

  lca_pkg::node_t  anc_mem [lca_pkg::ANC_DEPTH];
  lca_pkg::depth_t dep_mem [lca_pkg::NODE_COUNT];

  lca_pkg::anc_addr_t ra_a;
  lca_pkg::anc_addr_t ra_b;
  lca_pkg::anc_addr_t wa;
  lca_pkg::node_t     anc_qa_r;
  lca_pkg::node_t     anc_qb_r;
  logic               zero_a_r;
  logic               zero_b_r;
  lca_pkg::depth_t    dep_qa_r;
  lca_pkg::depth_t    dep_qb_r;

  logic               clr_r;
  logic               clr_nxt;
  lca_pkg::node_t     clr_idx_r;
  lca_pkg::node_t     clr_idx_nxt;
  logic               dep_we;
  lca_pkg::node_t     dep_wa;
  lca_pkg::depth_t    dep_wd;

  assign ra_a = lca_pkg::anc_addr(req.anc_rd_node_a, req.anc_rd_lvl_a);
  assign ra_b = lca_pkg::anc_addr(req.anc_rd_node_b, req.anc_rd_lvl_b);
  assign wa   = lca_pkg::anc_addr(req.anc_wr_node, req.anc_wr_lvl);

  // write-first: a read of the entry written in the same cycle sees the new data
  always_ff @(posedge clk) begin
    if (req.anc_we) begin
      anc_mem[wa] <= req.anc_wr_data;
    end
    anc_qa_r <= (req.anc_we && (wa == ra_a)) ? req.anc_wr_data : anc_mem[ra_a];
    anc_qb_r <= (req.anc_we && (wa == ra_b)) ? req.anc_wr_data : anc_mem[ra_b];
    zero_a_r <= (req.anc_rd_node_a == lca_pkg::NULL_NODE);
    zero_b_r <= (req.anc_rd_node_b == lca_pkg::NULL_NODE);
  end

  // sentinel node reads as all zero ancestors
  assign rsp.anc_q_a = zero_a_r ? lca_pkg::NULL_NODE : anc_qa_r;
  assign rsp.anc_q_b = zero_b_r ? lca_pkg::NULL_NODE : anc_qb_r;

  assign dep_we = clr_r || req.dep_we;
  assign dep_wa = clr_r ? clr_idx_r : req.dep_wr_node;
  assign dep_wd = clr_r ? '0 : req.dep_wr_data;

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
    dep_qa_r <= dep_mem[req.dep_rd_node_a];
    dep_qb_r <= dep_mem[req.dep_rd_node_b];
  end

  assign rsp.dep_q_a  = dep_qa_r;
  assign rsp.dep_q_b  = dep_qb_r;
  assign rsp.clearing = clr_r;

  always_comb begin
    clr_nxt     = clr_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + lca_pkg::node_t'(1);
      if (clr_idx_r == lca_pkg::node_t'(lca_pkg::NODE_COUNT - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

endmodule

// ----- design/lowest_common_ancestor_engine_unit.sv -----
`timescale 1ns / 1ps

// channel   ports                                   handshake
// request   in_cmd, in_node_a, in_node_b            start & !busy
// result    out_result_node                         out_strobe, one cycle, no stall
//
// Add: one ancestor table write per level, then the result strobes.
// Query: lifting costs two dependent reads per level (ancestor then depth), the
// common climb one dual-port read per level.
// Query naming the root, or an ignored add, strobes on the next cycle.
// After reset the whole depth table is cleared with busy high.

module lowest_common_ancestor_engine_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_cmd,
  input  lca_pkg::node_t         in_node_a,
  input  lca_pkg::node_t         in_node_b,
  output logic                   out_strobe,
  output lca_pkg::node_t         out_result_node
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ADD_DEP = 3'd1;
  localparam logic [2:0] S_ADD_LVL = 3'd2;
  localparam logic [2:0] S_Q_SWAP  = 3'd3;
  localparam logic [2:0] S_LIFT_A  = 3'd4;
  localparam logic [2:0] S_LIFT_D  = 3'd5;
  localparam logic [2:0] S_CMP     = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  localparam lca_pkg::lvl_t LVL_TOP = lca_pkg::lvl_t'(lca_pkg::LEVELS - 1);
  localparam lca_pkg::lvl_t LVL_ONE = lca_pkg::lvl_t'(1);
  localparam lca_pkg::lvl_t LVL_BOT = lca_pkg::lvl_t'(0);

  logic [2:0]       state_r, state_nxt;
  lca_pkg::node_t   x_r, x_nxt;
  lca_pkg::node_t   y_r, y_nxt;
  lca_pkg::node_t   up_r, up_nxt;
  lca_pkg::depth_t  dy_r, dy_nxt;
  lca_pkg::lvl_t    lvl_r, lvl_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  lca_pkg::node_t   out_result_r, out_result_nxt;

  lca_pkg::tbl_req_t req;
  lca_pkg::tbl_rsp_t rsp;

  lca_pkg::node_t   in_a;
  lca_pkg::node_t   in_b;
  logic             add_ok;
  lca_pkg::node_t   swap_x;
  lca_pkg::node_t   lift_x;
  lca_pkg::node_t   cmp_x;
  lca_pkg::node_t   cmp_y;
  logic             cmp_diff;

  lca_tables u_tables (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_a     = lca_pkg::map_node(in_node_a);
  assign in_b     = lca_pkg::map_node(in_node_b);
  assign add_ok   = (in_node_a != lca_pkg::NULL_NODE) && (in_a == in_node_a);
  assign swap_x   = (rsp.dep_q_a < rsp.dep_q_b) ? y_r : x_r;
  assign lift_x   = (rsp.dep_q_a >= dy_r) ? up_r : x_r;
  assign cmp_diff = (rsp.anc_q_a != rsp.anc_q_b);
  assign cmp_x    = cmp_diff ? rsp.anc_q_a : x_r;
  assign cmp_y    = cmp_diff ? rsp.anc_q_b : y_r;

  assign busy = rsp.clearing || (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    up_nxt         = up_r;
    dy_nxt         = dy_r;
    lvl_nxt        = lvl_r;
    out_strobe_nxt = 1'b0;
    out_result_nxt = out_result_r;
    req            = '0;
    unique case (state_r)
      S_IDLE: begin
        req.dep_rd_node_a = in_a;
        req.dep_rd_node_b = in_b;
        if (start && !busy) begin
          if (in_cmd == lca_pkg::CMD_ADD) begin
            if (add_ok) begin
              req.anc_we      = 1'b1;
              req.anc_wr_node = in_node_a;
              req.anc_wr_lvl  = LVL_BOT;
              req.anc_wr_data = in_b;
              x_nxt           = in_node_a;
              y_nxt           = in_b;
              state_nxt       = S_ADD_DEP;
            end else begin
              out_strobe_nxt = 1'b1;
              out_result_nxt = lca_pkg::NULL_NODE;
            end
          end else if ((in_a == lca_pkg::ROOT_NODE) || (in_b == lca_pkg::ROOT_NODE)) begin
            out_strobe_nxt = 1'b1;
            out_result_nxt = lca_pkg::ROOT_NODE;
          end else begin
            x_nxt     = in_a;
            y_nxt     = in_b;
            state_nxt = S_Q_SWAP;
          end
        end
      end
      S_ADD_DEP: begin
        req.dep_we        = 1'b1;
        req.dep_wr_node   = x_r;
        req.dep_wr_data   = (rsp.dep_q_b == lca_pkg::DEPTH_MAX) ? lca_pkg::DEPTH_MAX
                                                               : rsp.dep_q_b + 1'b1;
        req.anc_rd_node_a = y_r;
        req.anc_rd_lvl_a  = LVL_BOT;
        lvl_nxt           = LVL_ONE;
        if (lca_pkg::LEVELS == 1) begin
          out_strobe_nxt = 1'b1;
          out_result_nxt = lca_pkg::NULL_NODE;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_ADD_LVL;
        end
      end
      S_ADD_LVL: begin
        req.anc_we      = 1'b1;
        req.anc_wr_node = x_r;
        req.anc_wr_lvl  = lvl_r;
        req.anc_wr_data = rsp.anc_q_a;
        if (lvl_r == LVL_TOP) begin
          out_strobe_nxt = 1'b1;
          out_result_nxt = lca_pkg::NULL_NODE;
          state_nxt      = S_IDLE;
        end else begin
          req.anc_rd_node_a = rsp.anc_q_a;
          req.anc_rd_lvl_a  = lvl_r;
          lvl_nxt           = lvl_r + LVL_ONE;
        end
      end
      S_Q_SWAP: begin
        if (rsp.dep_q_a < rsp.dep_q_b) begin
          x_nxt  = y_r;
          y_nxt  = x_r;
          dy_nxt = rsp.dep_q_a;
        end else begin
          dy_nxt = rsp.dep_q_b;
        end
        req.anc_rd_node_a = swap_x;
        req.anc_rd_lvl_a  = LVL_TOP;
        lvl_nxt           = LVL_TOP;
        state_nxt         = S_LIFT_A;
      end
      S_LIFT_A: begin
        req.dep_rd_node_a = rsp.anc_q_a;
        up_nxt            = rsp.anc_q_a;
        state_nxt         = S_LIFT_D;
      end
      S_LIFT_D: begin
        x_nxt = lift_x;
        if (lvl_r == LVL_BOT) begin
          if (lift_x == y_r) begin
            out_strobe_nxt = 1'b1;
            out_result_nxt = lift_x;
            state_nxt      = S_IDLE;
          end else begin
            req.anc_rd_node_a = lift_x;
            req.anc_rd_lvl_a  = LVL_TOP;
            req.anc_rd_node_b = y_r;
            req.anc_rd_lvl_b  = LVL_TOP;
            lvl_nxt           = LVL_TOP;
            state_nxt         = S_CMP;
          end
        end else begin
          req.anc_rd_node_a = lift_x;
          req.anc_rd_lvl_a  = lvl_r - LVL_ONE;
          lvl_nxt           = lvl_r - LVL_ONE;
          state_nxt         = S_LIFT_A;
        end
      end
      S_CMP: begin
        x_nxt = cmp_x;
        y_nxt = cmp_y;
        if (lvl_r == LVL_BOT) begin
          req.anc_rd_node_a = cmp_x;
          req.anc_rd_lvl_a  = LVL_BOT;
          state_nxt         = S_FIN;
        end else begin
          req.anc_rd_node_a = cmp_x;
          req.anc_rd_lvl_a  = lvl_r - LVL_ONE;
          req.anc_rd_node_b = cmp_y;
          req.anc_rd_lvl_b  = lvl_r - LVL_ONE;
          lvl_nxt           = lvl_r - LVL_ONE;
        end
      end
      S_FIN: begin
        out_strobe_nxt = 1'b1;
        out_result_nxt = rsp.anc_q_a;
        state_nxt      = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    up_r         <= up_nxt;
    dy_r         <= dy_nxt;
    lvl_r        <= lvl_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_result_node = out_result_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int            STALL_LIMIT  = 4000;
  localparam int            LOOP_ROUNDS  = 6;
  localparam lca_pkg::node_t LOOP_NODE_A = 10'd1020;
  localparam lca_pkg::node_t LOOP_NODE_B = 10'd1021;
  localparam lca_pkg::node_t LOOP_CHILD  = 10'd1019;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  logic           in_cmd;
  lca_pkg::node_t in_node_a;
  lca_pkg::node_t in_node_b;
  logic           out_strobe;
  lca_pkg::node_t out_result_node;

  bit [lca_pkg::NODE_W-1:0]  anc_tbl [lca_pkg::NODE_COUNT][lca_pkg::LEVELS];
  bit [lca_pkg::DEPTH_W-1:0] dep_tbl [lca_pkg::NODE_COUNT];
  bit                        present [lca_pkg::NODE_COUNT];
  int                        present_list [$];
  lca_pkg::node_t            pending_answers [$];
  int                        fail_cnt;
  int                        quiet_cycles;
  bit                        gaps_on;

  lowest_common_ancestor_engine_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_node_a       (in_node_a),
    .in_node_b       (in_node_b),
    .out_strobe      (out_strobe),
    .out_result_node (out_result_node)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void insert_node(lca_pkg::node_t a, lca_pkg::node_t p);
    if (a == lca_pkg::NULL_NODE || int'(a) >= lca_pkg::NODE_COUNT) return;
    dep_tbl[a] = (dep_tbl[p] == lca_pkg::DEPTH_MAX) ? lca_pkg::DEPTH_MAX
                                                     : dep_tbl[p] + 1'b1;
    anc_tbl[a][0] = p;
    for (int k = 1; k < lca_pkg::LEVELS; k++)
      anc_tbl[a][k] = anc_tbl[anc_tbl[a][k-1]][k-1];
    if (!present[a]) begin
      present[a] = 1'b1;
      present_list.insert(present_list.size(), int'(a));
    end
  endfunction

  function automatic lca_pkg::node_t lca_of(lca_pkg::node_t x, lca_pkg::node_t y);
    lca_pkg::node_t t;
    if (x == lca_pkg::ROOT_NODE || y == lca_pkg::ROOT_NODE) return lca_pkg::ROOT_NODE;
    if (dep_tbl[x] < dep_tbl[y]) begin
      t = x;
      x = y;
      y = t;
    end
    for (int k = lca_pkg::LEVELS - 1; k >= 0; k--)
      if (dep_tbl[anc_tbl[x][k]] >= dep_tbl[y]) x = anc_tbl[x][k];
    if (x == y) return x;
    for (int k = lca_pkg::LEVELS - 1; k >= 0; k--) begin
      if (anc_tbl[x][k] != anc_tbl[y][k]) begin
        x = anc_tbl[x][k];
        y = anc_tbl[y][k];
      end
    end
    return anc_tbl[x][0];
  endfunction

  function automatic lca_pkg::node_t pick_present();
    return lca_pkg::node_t'(present_list[$urandom_range(present_list.size() - 1)]);
  endfunction

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(input logic cmd, input lca_pkg::node_t a,
                              input lca_pkg::node_t b);
    while (gaps_on && $urandom_range(99) < 11) begin
      start = 1'b0;
      @(negedge clk);
    end
    start     = 1'b1;
    in_cmd    = cmd;
    in_node_a = a;
    in_node_b = b;
    do @(posedge clk); while (busy);
    if (cmd == lca_pkg::CMD_QUERY) begin
      pending_answers.insert(pending_answers.size(), lca_of(a, b));
    end else begin
      insert_node(a, b);
      pending_answers.insert(pending_answers.size(), lca_pkg::NULL_NODE);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(lca_pkg::CMD_ADD,   lca_pkg::ROOT_NODE, lca_pkg::NULL_NODE);
    send_request(lca_pkg::CMD_QUERY, lca_pkg::ROOT_NODE, lca_pkg::ROOT_NODE);
    send_request(lca_pkg::CMD_ADD,   10'd2, lca_pkg::ROOT_NODE);
    send_request(lca_pkg::CMD_ADD,   10'd3, 10'd2);
    send_request(lca_pkg::CMD_ADD,   10'd1023, 10'd3);
    send_request(lca_pkg::CMD_ADD,   10'd512, 10'd2);
    send_request(lca_pkg::CMD_ADD,   10'd4, lca_pkg::ROOT_NODE);
    send_request(lca_pkg::CMD_QUERY, 10'd1023, 10'd512);
    send_request(lca_pkg::CMD_QUERY, 10'd512, 10'd1023);
    send_request(lca_pkg::CMD_QUERY, 10'd1023, 10'd3);
    send_request(lca_pkg::CMD_QUERY, 10'd3, 10'd1023);
    send_request(lca_pkg::CMD_QUERY, 10'd1023, 10'd1023);
    send_request(lca_pkg::CMD_QUERY, 10'd4, 10'd1023);
    send_request(lca_pkg::CMD_QUERY, 10'd1023, lca_pkg::ROOT_NODE);
    send_request(lca_pkg::CMD_QUERY, 10'd2, lca_pkg::NULL_NODE);
    send_request(lca_pkg::CMD_ADD,   lca_pkg::NULL_NODE, 10'd3);
    send_request(lca_pkg::CMD_QUERY, 10'd3, 10'd4);
    send_request(lca_pkg::CMD_ADD,   10'd512, 10'd1023);
    send_request(lca_pkg::CMD_QUERY, 10'd512, 10'd4);
    send_request(lca_pkg::CMD_QUERY, 10'd512, 10'd3);
    send_request(lca_pkg::CMD_ADD,   10'd5, lca_pkg::NULL_NODE);
    send_request(lca_pkg::CMD_QUERY, 10'd5, 10'd1023);
    send_request(lca_pkg::CMD_QUERY, 10'd1023, 10'd5);
  endtask

  // long chain so lifting reaches the top jump level
  task automatic test_deep_chain();
    int             pool [$];
    int             idx;
    lca_pkg::node_t tip;
    lca_pkg::node_t n;
    tip = lca_pkg::ROOT_NODE;
    for (int v = 2; v < int'(LOOP_CHILD); v++)
      if (!present[v]) pool.insert(pool.size(), v);
    for (int i = 0; i < 800; i++) begin
      if ($urandom_range(99) < 80 && pool.size() > 0) begin
        idx = $urandom_range(pool.size() - 1);
        n   = lca_pkg::node_t'(pool[idx]);
        pool.delete(idx);
        if ($urandom_range(9) == 0) begin
          send_request(lca_pkg::CMD_ADD, n, pick_present());
        end else begin
          send_request(lca_pkg::CMD_ADD, n, tip);
          tip = n;
        end
      end else begin
        send_request(lca_pkg::CMD_QUERY, ($urandom_range(1) != 0) ? tip : pick_present(),
                     pick_present());
      end
    end
  endtask

  task automatic test_random();
    int             sel;
    lca_pkg::node_t a;
    lca_pkg::node_t b;
    for (int i = 0; i < 450; i++) begin
      sel = $urandom_range(99);
      if (sel < 38) begin
        a = lca_pkg::node_t'($urandom_range(1, lca_pkg::NODE_COUNT - 1));
        sel = $urandom_range(99);
        if (sel < 5)      b = lca_pkg::NULL_NODE;
        else if (sel < 7) b = present[a] ? a : pick_present();
        else              b = pick_present();
        send_request(lca_pkg::CMD_ADD, a, b);
      end else if (sel < 41) begin
        send_request(lca_pkg::CMD_ADD, lca_pkg::NULL_NODE, pick_present());
      end else begin
        a = ($urandom_range(19) == 0) ? lca_pkg::ROOT_NODE : pick_present();
        sel = $urandom_range(99);
        if (sel < 5)       b = lca_pkg::NULL_NODE;
        else if (sel < 15) b = a;
        else if (sel < 20) b = lca_pkg::ROOT_NODE;
        else               b = pick_present();
        send_request(lca_pkg::CMD_QUERY, a, b);
      end
    end
  endtask

  // two nodes re-added under each other, forming a cycle
  task automatic test_cycle_readd();
    send_request(lca_pkg::CMD_ADD, LOOP_NODE_A, lca_pkg::ROOT_NODE);
    send_request(lca_pkg::CMD_ADD, LOOP_NODE_B, LOOP_NODE_A);
    for (int i = 0; i < LOOP_ROUNDS; i++) begin
      send_request(lca_pkg::CMD_ADD, LOOP_NODE_A, LOOP_NODE_B);
      send_request(lca_pkg::CMD_ADD, LOOP_NODE_B, LOOP_NODE_A);
    end
    send_request(lca_pkg::CMD_ADD,   LOOP_NODE_A, LOOP_NODE_B);
    send_request(lca_pkg::CMD_ADD,   LOOP_CHILD, LOOP_NODE_A);
    send_request(lca_pkg::CMD_QUERY, LOOP_NODE_A, LOOP_NODE_B);
    send_request(lca_pkg::CMD_QUERY, LOOP_CHILD, LOOP_NODE_B);
    send_request(lca_pkg::CMD_QUERY, LOOP_CHILD, pick_present());
    send_request(lca_pkg::CMD_QUERY, pick_present(), LOOP_NODE_A);
    send_request(lca_pkg::CMD_QUERY, LOOP_CHILD, lca_pkg::NULL_NODE);
  endtask

  always @(posedge clk) begin : check_results
    lca_pkg::node_t want;
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("lowest_common_ancestor_engine_unit: mismatch");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        $error("result_node: expected none, actual %0d", out_result_node);
        fail_cnt++;
      end else begin
        want = pending_answers.pop_front();
        if (out_result_node !== want) begin
          $error("result_node: expected %0d, actual %0d", want, out_result_node);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    fail_cnt     = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b1;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = lca_pkg::CMD_ADD;
    in_node_a    = lca_pkg::NULL_NODE;
    in_node_b    = lca_pkg::NULL_NODE;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    drain();
    gaps_on = 1'b0;
    test_deep_chain();
    drain();
    gaps_on = 1'b1;
    test_random();
    test_cycle_readd();
    drain();
    repeat (40) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("lowest_common_ancestor_engine_unit: match");
    end else begin
      $display("lowest_common_ancestor_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lca_pkg.sv
design/lca_tables.sv
design/lowest_common_ancestor_engine_unit.sv
tb/tb.sv
